[rtl/core/fir8s_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fir8s_pkg;

  localparam int SAMPLE_W    = 8;
  localparam int MAX_TAPS    = 8;
  localparam int TAP_IDX_W   = $clog2(MAX_TAPS);
  localparam int CFG_INDEX_W = 4;
  localparam int PROD_W      = 2 * SAMPLE_W;
  localparam int FRAC_BITS   = 7;

  localparam logic [SAMPLE_W-1:0] OFFSET = 8'h80;
  localparam int SAT_MAX = 127;
  localparam int SAT_MIN = -128;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SAMPLE_W-1:0] weight_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic [CFG_INDEX_W-1:0]     cfg_index_t;

endpackage

`default_nettype wire

[rtl/core/fir8s_delay_line.sv]
`timescale 1ns / 1ps
`default_nettype none

module fir8s_delay_line #(
  parameter int TAPS = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              en,
  input  wire logic                              in_valid,
  input  wire logic [fir8s_pkg::SAMPLE_W-1:0]    sample_in,
  output      logic                              tap_valid,
  output      fir8s_pkg::sample_t                taps [TAPS]
);
  import fir8s_pkg::*;

  sample_t line [TAPS-1];
  sample_t cur;

  // offset binary to two's complement
  assign cur = sample_t'(sample_in ^ OFFSET);

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_valid <= 1'b0;
      for (int k = 0; k < TAPS - 1; k++) begin
        line[k] <= '0;
      end
    end else if (en) begin
      tap_valid <= in_valid;
      if (in_valid) begin
        line[0] <= cur;
        for (int k = 1; k < TAPS - 1; k++) begin
          line[k] <= line[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      taps[0] <= cur;
      for (int k = 1; k < TAPS; k++) begin
        taps[k] <= line[k-1];
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/fir8s_mac.sv]
`timescale 1ns / 1ps
`default_nettype none

module fir8s_mac #(
  parameter int TAPS = 8
) (
  input  wire logic                                                   clk,
  input  wire logic                                                   rst,
  input  wire logic                                                   en,
  input  wire logic                                                   in_valid,
  input  wire fir8s_pkg::sample_t                                     taps [TAPS],
  input  wire fir8s_pkg::weight_t                                     weights [TAPS],
  output      logic                                                   prod_valid,
  output      logic                                                   acc_valid,
  output      logic signed [fir8s_pkg::PROD_W+$clog2(TAPS)-1:0]       acc
);
  import fir8s_pkg::*;

  localparam int ACC_W = PROD_W + $clog2(TAPS);

  prod_t                   prod [TAPS];
  logic signed [ACC_W-1:0] sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      acc_valid  <= 1'b0;
    end else if (en) begin
      prod_valid <= in_valid;
      acc_valid  <= prod_valid;
    end
  end

  // one product per tap, all in parallel
  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      for (int k = 0; k < TAPS; k++) begin
        prod[k] <= prod_t'(taps[k] * weights[k]);
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int k = 0; k < TAPS; k++) begin
      sum = sum + ACC_W'(prod[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en && prod_valid) begin
      acc <= sum;
    end
  end

endmodule

`default_nettype wire

[rtl/core/fir8s_sat.sv]
`timescale 1ns / 1ps
`default_nettype none

module fir8s_sat #(
  parameter int TAPS = 8
) (
  input  wire logic                                               clk,
  input  wire logic                                               rst,
  input  wire logic                                               en,
  input  wire logic                                               in_valid,
  input  wire logic signed [fir8s_pkg::PROD_W+$clog2(TAPS)-1:0]   acc,
  output      logic                                               out_valid,
  output      logic [fir8s_pkg::SAMPLE_W-1:0]                     out_data
);
  import fir8s_pkg::*;

  localparam int ACC_W = PROD_W + $clog2(TAPS);
  localparam int SH_W  = ACC_W - FRAC_BITS;

  logic signed [SH_W-1:0] shifted;
  sample_t                clipped;

  // arithmetic shift rounds toward minus infinity
  assign shifted = SH_W'(acc >>> FRAC_BITS);

  always_comb begin
    if (shifted > SH_W'(SAT_MAX)) begin
      clipped = sample_t'(SAT_MAX);
    end else if (shifted < SH_W'(SAT_MIN)) begin
      clipped = sample_t'(SAT_MIN);
    end else begin
      clipped = sample_t'(shifted);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      out_data <= clipped ^ OFFSET;
    end
  end

endmodule

`default_nettype wire

[rtl/core/fir_filter_8tap_saturating.sv]
// path: an accepted input item moves through the tap, product, sum and output registers to output item valid
// throughput: one item per cycle through the tap, product, sum and output registers while the output is not stalled
// a stalled output holds every stage, so s_axis_tready is m_axis_tready or an empty output
// reset: synchronous, active high; clears the delay line storage to signed zero (tap output
// registers are not reset), all tap weights to zero and all stage valid flags
`timescale 1ns / 1ps
`default_nettype none

module fir_filter_8tap_saturating #(
  parameter int TAPS = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_axis_tvalid,
  output      logic                                s_axis_tready,
  input  wire logic [fir8s_pkg::SAMPLE_W-1:0]      s_axis_tdata,   // [7:0] sample_in
  output      logic                                m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output      logic [fir8s_pkg::SAMPLE_W-1:0]      m_axis_tdata,   // [7:0] sample_out
  input  wire logic                                cfg_valid,
  output      logic                                cfg_ready,
  input  wire fir8s_pkg::cfg_index_t               cfg_index,
  input  wire logic [fir8s_pkg::SAMPLE_W-1:0]      cfg_data
);
  import fir8s_pkg::*;

  localparam int ACC_W = PROD_W + $clog2(TAPS);

  weight_t                 tap_weight [MAX_TAPS];
  weight_t                 use_weight [TAPS];
  sample_t                 taps [TAPS];
  logic                    en;
  logic                    tap_valid;
  logic                    prod_valid;
  logic                    acc_valid;
  logic signed [ACC_W-1:0] acc;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_TAPS; k++) begin
        tap_weight[k] <= '0;
      end
    end else if (cfg_valid && (cfg_index < CFG_INDEX_W'(MAX_TAPS))) begin
      tap_weight[cfg_index[TAP_IDX_W-1:0]] <= weight_t'(cfg_data);
    end
  end

  always_comb begin
    for (int k = 0; k < TAPS; k++) begin
      use_weight[k] = tap_weight[k];
    end
  end

  fir8s_delay_line #(
    .TAPS (TAPS)
  ) u_delay_line (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_axis_tvalid),
    .sample_in (s_axis_tdata),
    .tap_valid (tap_valid),
    .taps      (taps)
  );

  fir8s_mac #(
    .TAPS (TAPS)
  ) u_mac (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (tap_valid),
    .taps       (taps),
    .weights    (use_weight),
    .prod_valid (prod_valid),
    .acc_valid  (acc_valid),
    .acc        (acc)
  );

  fir8s_sat #(
    .TAPS (TAPS)
  ) u_sat (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (acc_valid),
    .acc       (acc),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata)
  );

`ifndef SYNTHESIS
  a_accept_to_taps: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> tap_valid)
    else $error("accepted item did not reach tap stage");

  a_taps_to_prod: assert property (@(posedge clk) disable iff (rst)
    tap_valid && en |=> prod_valid)
    else $error("tap stage item lost before product stage");

  a_acc_to_out: assert property (@(posedge clk) disable iff (rst)
    acc_valid && en |=> m_axis_tvalid)
    else $error("sum stage item lost before output");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en && prod_valid |=> prod_valid)
    else $error("stage emptied while output stalled");
`endif

endmodule

`default_nettype wire
